>>> rtl/tdpt_pkg.sv
package tdpt_pkg;

  // Result code width and codes
  localparam int VERDICT_W = 2;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NEITHER   = 2'd0,
    VERDICT_PRIME     = 2'd1,
    VERDICT_COMPOSITE = 2'd2
  } verdict_t;

  // Output word is the verdict padded to one byte
  localparam int M_DATA_W = 8;

endpackage

>>> rtl/trial_division_prime_test.sv
// Trial-division prime test. Each input word carries one unsigned value; the block
// answers with one output word whose verdict is 0 (neither: zero or one), 1 (prime)
// or 2 (composite). Zero, one and even values of four or more are answered without
// trial division. Odd values test odd divisors d = 3, 5, 7, ... while d*d <= value;
// each candidate takes a bound compare, then a remainder found by a bit-serial
// restoring divider that takes one value bit per cycle. One value is worked on at a
// time; a finished verdict waits in the output register while the next value is
// taken.
module trial_division_prime_test #(
  parameter int VALUE_BITS = 31
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,   // [VALUE_BITS-1:0] value
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tdpt_pkg::M_DATA_W-1:0]       m_tdata    // [1:0] verdict
);

  localparam int S_DATA_W = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CNT_W    = $clog2(VALUE_BITS);
  localparam int SQ_W     = VALUE_BITS + 1;
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_RESULT
  } state_t;

  state_t                    state;
  logic [VALUE_BITS-1:0]     n;        // value under test
  logic [VALUE_BITS-1:0]     n_sh;     // value shifted out MSB first
  logic [VALUE_BITS-1:0]     d;        // candidate divisor
  logic [SQ_W-1:0]           sq;       // d*d kept incrementally
  logic [VALUE_BITS-1:0]     r;        // partial remainder, below d during a division
  logic [CNT_W-1:0]          cnt;      // division bits left after the current one
  tdpt_pkg::verdict_t        verdict;

  logic [VALUE_BITS-1:0]     in_value;
  logic [VALUE_BITS:0]       trial;
  logic                      fits;
  logic [VALUE_BITS-1:0]     r_next;
  logic [SQ_W:0]             sq_sum;
  logic [SQ_W-1:0]           sq_next;

  assign in_value = s_tdata[VALUE_BITS-1:0];
  assign s_tready = (state == ST_IDLE);

  // One restoring division step
  assign trial  = {r, n_sh[VALUE_BITS-1]};
  assign fits   = (trial >= {1'b0, d});
  assign r_next = fits ? VALUE_BITS'(trial - {1'b0, d}) : trial[VALUE_BITS-1:0];

  // (d+2)^2 = d^2 + 4d + 4
  assign sq_sum  = {1'b0, sq} + {d, 2'b00} + (SQ_W + 1)'(4);
  assign sq_next = sq_sum[SQ_W-1:0];

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_RESULT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            n  <= in_value;
            d  <= VALUE_BITS'(3);
            sq <= SQ_W'(9);
            if (in_value < VALUE_BITS'(2)) begin
              verdict <= tdpt_pkg::VERDICT_NEITHER;
              state   <= ST_RESULT;
            end else if (in_value >= VALUE_BITS'(4) && !in_value[0]) begin
              verdict <= tdpt_pkg::VERDICT_COMPOSITE;
              state   <= ST_RESULT;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (sq > {1'b0, n}) begin
            verdict <= tdpt_pkg::VERDICT_PRIME;
            state   <= ST_RESULT;
          end else begin
            n_sh  <= n;
            r     <= '0;
            cnt   <= LAST_BIT;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          r    <= r_next;
          n_sh <= {n_sh[VALUE_BITS-2:0], 1'b0};
          cnt  <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            if (r_next == '0) begin
              verdict <= tdpt_pkg::VERDICT_COMPOSITE;
              state   <= ST_RESULT;
            end else begin
              d     <= d + VALUE_BITS'(2);
              sq    <= sq_next;
              state <= ST_CHECK;
            end
          end
        end
        ST_RESULT: begin
          // Load when the register is free or being drained this cycle
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(tdpt_pkg::M_DATA_W - tdpt_pkg::VERDICT_W)'(0), verdict};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Partial remainder stays below the divisor during a division
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (r < d))
    else $error("remainder not below divisor");

  // Divisors tried are odd and at least three
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK || state == ST_DIV) |-> (d[0] && d >= VALUE_BITS'(3)))
    else $error("bad candidate divisor");

  // The code 3 is never sent
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("invalid verdict code");

  // A new output word is loaded only from the result state
  assert property (@(posedge clk) disable iff (rst)
    (!$past(m_tvalid) && m_tvalid && !$past(rst)) |-> ($past(state) == ST_RESULT))
    else $error("output loaded outside result state");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int VALUE_BITS = 31;
  localparam int S_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 400;

  // Expected verdicts for accepted values, checked in order against output words
  class verdict_board;
    tdpt_pkg::verdict_t pending_verdicts[$];
    int unsigned failures;
    int unsigned checked;
    int unsigned tally[3];

    // Trial division over odd divisors, bound kept as d <= n / d
    function tdpt_pkg::verdict_t expected_verdict(bit [VALUE_BITS-1:0] n);
      longint unsigned num;
      longint unsigned d;
      num = 64'(n);
      if (num < 2) return tdpt_pkg::VERDICT_NEITHER;
      if (num >= 4 && num[0] == 1'b0) return tdpt_pkg::VERDICT_COMPOSITE;
      for (d = 3; d <= num / d; d += 2) begin
        if (num % d == 0) return tdpt_pkg::VERDICT_COMPOSITE;
      end
      return tdpt_pkg::VERDICT_PRIME;
    endfunction

    // Bits above the value field are ignored by the block
    function void note_value(bit [S_DATA_W-1:0] word);
      pending_verdicts.push_back(expected_verdict(word[VALUE_BITS-1:0]));
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      failures++;
    endtask

    task check_word(logic [tdpt_pkg::M_DATA_W-1:0] word);
      tdpt_pkg::verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("output word %0h with no value outstanding", word));
      end else begin
        want = pending_verdicts.pop_front();
        checked++;
        tally[want]++;
        if (word[tdpt_pkg::VERDICT_W-1:0] !== want)
          report_mismatch($sformatf("verdict %0d, expected %s",
                                    word[tdpt_pkg::VERDICT_W-1:0], want.name()));
      end
    endtask
  endclass

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [S_DATA_W-1:0]           s_tdata = '0;   // [30:0] value
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [tdpt_pkg::M_DATA_W-1:0] m_tdata;        // [1:0] verdict

  verdict_board board;
  int           recv_stall_pct = 0;
  bit           hold_active = 1'b0;
  event         hold_go;

  trial_division_prime_test #(.VALUE_BITS(VALUE_BITS)) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog, far beyond the slowest legal run (one full-width prime dominates)
  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

  // Output-side ready: random stalls, or a long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_active) m_tready <= 1'b0;
      else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    forever begin
      @(hold_go);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  // Output word monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata);
  end

  // Offer one word and hold it until taken
  task send_value(bit [S_DATA_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_value(word);
  endtask

  // Drop valid with junk on the data lines; n (n >= 1) sets the length of the pause
  task sender_pause(int n);
    s_tvalid <= 1'b0;
    s_tdata  <= S_DATA_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task wait_drained();
    while (board.pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Mostly small values; full-width ones are kept cheap (even or a multiple of 3)
  function bit [S_DATA_W-1:0] random_value();
    bit [S_DATA_W-1:0] word;
    bit [VALUE_BITS-1:0] n;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick <= 5) n = VALUE_BITS'($urandom_range(4095));
    else if (pick <= 7) n = VALUE_BITS'($urandom_range(1 << 18, 4096));
    else begin
      n = VALUE_BITS'($urandom);
      if ($urandom_range(1)) n[0] = 1'b0;
      else n = VALUE_BITS'(n - (n % 3));
    end
    word = S_DATA_W'(n);
    word[S_DATA_W-1] = 1'($urandom_range(1));
    return word;
  endfunction

  task run_phase(int count, int send_idle_pct, int recv_idle_pct);
    recv_stall_pct = recv_idle_pct;
    repeat (count) begin
      send_value(random_value());
      if ($urandom_range(99) < send_idle_pct) sender_pause($urandom_range(8, 1));
    end
    sender_pause(1);
    wait_drained();
  endtask

  bit [S_DATA_W-1:0] directed_words[$];

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero, one, tiny primes, prime squares, 16-bit extremes, full-width extremes,
    // and words with the stray bit above the value field set
    directed_words = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8,
                       32'd9, 32'd15, 32'd25, 32'd49, 32'd121, 32'd63001, 32'd65521,
                       32'd65535, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFD,
                       32'h8000_0000, 32'h8000_0001, 32'h8000_0007, 32'hFFFF_FFFE,
                       32'h8000_FFF1};
    recv_stall_pct = 0;
    foreach (directed_words[i]) send_value(directed_words[i]);
    sender_pause(1);
    wait_drained();

    run_phase(20, 0, 0);
    run_phase(20, 72, 0);
    run_phase(20, 0, 72);
    run_phase(20, 6, 6);

    // Hold the output off while the input keeps offering words
    recv_stall_pct = 0;
    -> hold_go;
    run_phase(20, 0, 0);

    repeat (50) @(posedge clk);
    $display("Checked %0d verdicts: %0d neither, %0d prime, %0d composite.", board.checked,
             board.tally[tdpt_pkg::VERDICT_NEITHER], board.tally[tdpt_pkg::VERDICT_PRIME],
             board.tally[tdpt_pkg::VERDICT_COMPOSITE]);
    $display("Traffic: full rate, input gaps, output stalls, both, and a %0d-cycle hold.",
             HOLD_CYCLES);
    if (board.failures == 0 && board.pending_verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> trial_division_prime_test.f
rtl/tdpt_pkg.sv
rtl/trial_division_prime_test.sv
tb/testbench.sv
